// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WST_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define WST_ASSERT(lbl, prop, msg)
`define WST_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/wst_pkg.sv =====
// ----------------------------------------------------------------------------
// wst_pkg
// Shared types and constants of the wavetable sound channels.
// ----------------------------------------------------------------------------
`default_nettype none
package wst_pkg;
  localparam int NumChannels = 8;
  localparam int RamBytes    = 128;
  localparam int RamAw       = 7;
  localparam int ChanCnt     = 8;
  localparam int ChanAw      = 3;

  typedef enum logic [1:0] {
    OP_ADDR  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  localparam logic CfgTickStep = 1'b0;
  localparam logic CfgMasterVol = 1'b1;

  localparam logic [2:0] RegFreqLo  = 3'd0;
  localparam logic [2:0] RegFreqMid = 3'd2;
  localparam logic [2:0] RegFreqHi  = 3'd4;
  localparam logic [2:0] RegWave    = 3'd6;
  localparam logic [2:0] RegVol     = 3'd7;

  localparam int PendFreq = 0;
  localparam int PendLen  = 1;
  localparam int PendVol  = 2;

  localparam logic [5:0] LenFull    = 6'h20;
  localparam logic [5:0] LenReset   = 6'h10;
  localparam logic [23:0] TickReset = 24'd11350000;
  localparam logic [8:0] MvolReset  = 9'd256;

  typedef struct packed {
    logic [17:0]        step;
    logic [5:0]         units;
    logic [22:0]        phase;
    logic signed [25:0] credit;
    logic [3:0]         vol;
  } chan_t;

  localparam int ChanW = $bits(chan_t);
endpackage
`default_nettype wire

// ===== rtl/wst_ram.sv =====
// ----------------------------------------------------------------------------
// wst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module wst_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/wavetable_sound_channels.sv =====
// ----------------------------------------------------------------------------
// wavetable_sound_channels
// Eight-channel 4-bit wavetable synth with a 128-byte sound RAM.
// ----------------------------------------------------------------------------
// Address write and data write transactions finish in the cycle after they are
// accepted, a data read goes through S_READ first. A tick walks the active
// channels through the sound RAM port in states S_LD, S_F0, S_F2, S_F4, S_V,
// S_STEP and S_SMP, with S_STEP repeated once per credit wrap, then mixes in
// S_MIX and S_OUT. Each result shows on result_valid_o for one cycle and the
// receiver cannot stall it; busy_o is low while the next transaction may start.
`default_nettype none
`include "assert_macros.svh"
module wavetable_sound_channels
  import wst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         bus_byte_i,
  output logic                    result_valid_o,
  output logic      [7:0]         read_byte_o,
  output logic signed [14:0]      sample_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [23:0]        cfg_data_i
);
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_READ = 11'b00000000010,
    S_LD   = 11'b00000000100,
    S_F0   = 11'b00000001000,
    S_F2   = 11'b00000010000,
    S_F4   = 11'b00000100000,
    S_V    = 11'b00001000000,
    S_STEP = 11'b00010000000,
    S_SMP  = 11'b00100000000,
    S_MIX  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [RamAw-1:0] ptr_q, ptr_d;
  logic auto_q, auto_d;
  logic [3:0] active_q, active_d;
  logic [2:0] pend_q [ChanCnt];
  logic [2:0] pend_d [ChanCnt];
  logic [7:0] wstart_q [ChanCnt];
  logic [7:0] wstart_d [ChanCnt];
  logic [RamBytes-1:0] snd_vld_q, snd_vld_d;
  logic [ChanCnt-1:0] chan_vld_q, chan_vld_d;
  logic [23:0] tick_step_q;
  logic [8:0] mvol_q;
  logic [ChanAw-1:0] ch_q, ch_d;
  logic [3:0] cnt_q, cnt_d;
  logic signed [10:0] sum_q, sum_d;
  chan_t rec_q, rec_d;
  logic [7:0] f0_q, f0_d, f2_q, f2_d, f4_q, f4_d;
  logic signed [20:0] prod_q, prod_d;
  logic idx_lsb_q, idx_lsb_d;
  logic out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic signed [14:0] out_smp_q, out_smp_d;
  logic snd_rvld_q, chan_rvld_q;

  logic snd_we;
  logic [RamAw-1:0] snd_raddr;
  logic [7:0] snd_rraw, snd_rdata;
  logic chan_we;
  logic [ChanW-1:0] chan_rraw;
  chan_t chan_rdata, chan_rst;

  logic accept;
  logic [3:0] cnt_clip;
  logic [5:0] new_units;
  logic [23:0] ph_sum, ph_len;
  logic [7:0] idx;
  logic [3:0] nib;
  logic signed [9:0] term;
  logic signed [16:0] shifted;

  wst_ram #(.Width(8), .Depth(RamBytes)) u_snd_ram (
    .clk_i   (clk_i),
    .we_i    (snd_we),
    .waddr_i (ptr_q),
    .wdata_i (bus_byte_i),
    .raddr_i (snd_raddr),
    .rdata_o (snd_rraw)
  );

  wst_ram #(.Width(ChanW), .Depth(ChanCnt)) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (ch_q),
    .wdata_i (rec_q),
    .raddr_i (ch_q),
    .rdata_o (chan_rraw)
  );

  always_comb begin
    chan_rst = '0;
    chan_rst.units = LenReset;
  end

  assign snd_rdata  = snd_rvld_q ? snd_rraw : 8'h00;
  assign chan_rdata = chan_rvld_q ? chan_t'(chan_rraw) : chan_rst;
  assign accept     = start_i && (state_q == S_IDLE);
  assign cnt_clip   = (active_q > 4'(NumChannels)) ? 4'(NumChannels) : active_q;
  assign new_units  = LenFull - {1'b0, f4_q[4:2], 2'b00};
  assign ph_sum     = {1'b0, rec_q.phase} + {6'd0, rec_q.step};
  assign ph_len     = {rec_q.units, 18'd0};
  assign idx        = {3'd0, rec_q.phase[22:18]} + wstart_q[ch_q];
  assign nib        = idx_lsb_q ? snd_rdata[7:4] : snd_rdata[3:0];
  assign term       = (signed'({1'b0, nib}) - 5'sd8) * signed'({1'b0, rec_q.vol});
  assign shifted    = 17'(prod_q >>> 4);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    auto_d     = auto_q;
    active_d   = active_q;
    pend_d     = pend_q;
    wstart_d   = wstart_q;
    snd_vld_d  = snd_vld_q;
    chan_vld_d = chan_vld_q;
    ch_d       = ch_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    rec_d      = rec_q;
    f0_d       = f0_q;
    f2_d       = f2_q;
    f4_d       = f4_q;
    prod_d     = prod_q;
    idx_lsb_d  = idx_lsb_q;
    out_vld_d  = 1'b0;
    out_byte_d = out_byte_q;
    out_smp_d  = out_smp_q;
    snd_we     = 1'b0;
    snd_raddr  = ptr_q;
    chan_we    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(op_i))
            OP_ADDR: begin
              ptr_d      = bus_byte_i[6:0];
              auto_d     = bus_byte_i[7];
              out_vld_d  = 1'b1;
              out_byte_d = 8'h00;
              out_smp_d  = '0;
            end
            OP_WRITE: begin
              snd_we           = 1'b1;
              snd_vld_d[ptr_q] = 1'b1;
              if (ptr_q[6]) begin
                case (ptr_q[2:0]) inside
                  RegFreqLo, RegFreqMid: pend_d[ptr_q[5:3]][PendFreq] = 1'b1;
                  RegFreqHi: pend_d[ptr_q[5:3]][PendLen] = 1'b1;
                  RegWave: wstart_d[ptr_q[5:3]] = bus_byte_i;
                  RegVol: begin
                    pend_d[ptr_q[5:3]][PendVol] = 1'b1;
                    if (ptr_q[5:3] == 3'd7) begin
                      active_d = {1'b0, bus_byte_i[6:4]} + 4'd1;
                    end
                  end
                  default: ;
                endcase
              end
              if (auto_q) ptr_d = ptr_q + 7'd1;
              out_vld_d  = 1'b1;
              out_byte_d = 8'h00;
              out_smp_d  = '0;
            end
            OP_READ: begin
              if (auto_q) ptr_d = ptr_q + 7'd1;
              state_d = S_READ;
            end
            OP_TICK: begin
              cnt_d   = cnt_clip;
              ch_d    = ChanAw'(4'd8 - cnt_clip);
              sum_d   = '0;
              state_d = S_LD;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        out_vld_d  = 1'b1;
        out_byte_d = snd_rdata;
        out_smp_d  = '0;
        state_d    = S_IDLE;
      end
      S_LD: begin
        snd_raddr = {1'b1, ch_q, RegFreqLo};
        state_d   = S_F0;
      end
      S_F0: begin
        rec_d     = chan_rdata;
        f0_d      = snd_rdata;
        snd_raddr = {1'b1, ch_q, RegFreqMid};
        state_d   = S_F2;
      end
      S_F2: begin
        f2_d      = snd_rdata;
        snd_raddr = {1'b1, ch_q, RegFreqHi};
        state_d   = S_F4;
      end
      S_F4: begin
        f4_d      = snd_rdata;
        snd_raddr = {1'b1, ch_q, RegVol};
        state_d   = S_V;
      end
      S_V: begin
        if (pend_q[ch_q][PendFreq] || pend_q[ch_q][PendLen]) begin
          rec_d.step = {f4_q[1:0], f2_q, f0_q};
        end
        if (pend_q[ch_q][PendLen] && (new_units != rec_q.units)) begin
          rec_d.units = new_units;
          rec_d.phase = '0;
        end
        if (pend_q[ch_q][PendVol]) rec_d.vol = snd_rdata[3:0];
        rec_d.credit = rec_q.credit - signed'({2'b00, tick_step_q});
        pend_d[ch_q] = 3'b000;
        state_d      = S_STEP;
      end
      S_STEP: begin
        if (rec_q.credit[25]) begin
          rec_d.credit = rec_q.credit + signed'({2'b00, cnt_q, 20'd0});
          rec_d.phase  = (ph_sum >= ph_len) ? 23'(ph_sum - ph_len) : ph_sum[22:0];
        end else begin
          snd_raddr        = idx[7:1];
          idx_lsb_d        = idx[0];
          chan_we          = 1'b1;
          chan_vld_d[ch_q] = 1'b1;
          state_d          = S_SMP;
        end
      end
      S_SMP: begin
        sum_d = sum_q + 11'(term);
        if (ch_q == 3'd7) begin
          state_d = S_MIX;
        end else begin
          ch_d    = ch_q + 3'd1;
          state_d = S_LD;
        end
      end
      S_MIX: begin
        prod_d  = sum_q * signed'({1'b0, mvol_q});
        state_d = S_OUT;
      end
      S_OUT: begin
        if (shifted > 17'sd16383) out_smp_d = 15'sd16383;
        else if (shifted < -17'sd16384) out_smp_d = -15'sd16384;
        else out_smp_d = 15'(shifted);
        out_byte_d = 8'h00;
        out_vld_d  = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      auto_q      <= 1'b1;
      active_q    <= 4'd8;
      pend_q      <= '{default: 3'b000};
      wstart_q    <= '{default: 8'h00};
      snd_vld_q   <= '0;
      chan_vld_q  <= '0;
      tick_step_q <= TickReset;
      mvol_q      <= MvolReset;
      out_vld_q   <= 1'b0;
      ch_q        <= '0;
      cnt_q       <= 4'd8;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      auto_q     <= auto_d;
      active_q   <= active_d;
      pend_q     <= pend_d;
      wstart_q   <= wstart_d;
      snd_vld_q  <= snd_vld_d;
      chan_vld_q <= chan_vld_d;
      out_vld_q  <= out_vld_d;
      ch_q       <= ch_d;
      cnt_q      <= cnt_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgTickStep) tick_step_q <= cfg_data_i;
        else if (cfg_index_i == CfgMasterVol) mvol_q <= cfg_data_i[8:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q       <= sum_d;
    rec_q       <= rec_d;
    f0_q        <= f0_d;
    f2_q        <= f2_d;
    f4_q        <= f4_d;
    prod_q      <= prod_d;
    idx_lsb_q   <= idx_lsb_d;
    out_byte_q  <= out_byte_d;
    out_smp_q   <= out_smp_d;
    snd_rvld_q  <= snd_vld_q[snd_raddr];
    chan_rvld_q <= chan_vld_q[ch_q];
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = out_vld_q;
  assign read_byte_o    = out_byte_q;
  assign sample_o       = out_smp_q;

  `WST_ASSERT(a_phase_in_range, (state_q == S_STEP) |-> ({1'b0, rec_q.phase} < ph_len), "phase beyond wave length")
  `WST_ASSERT_NEVER(a_one_field, result_valid_o && (read_byte_o != 8'h00) && (sample_o != 15'sd0), "both result fields set")
  `WST_ASSERT(a_start_progress, (start_i && !busy_o) |=> (busy_o || result_valid_o), "accepted transaction lost")
endmodule
`default_nettype wire
